/* design/mt_pkg.sv */
// ----------------------------------------------------------------------------
// mt_pkg
// Shared types, character codes and helpers for the markup tokenizer.
// ----------------------------------------------------------------------------
package mt_pkg;

  // token kinds as they leave the block
  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_SINGLE = 2'd2;
  localparam logic [1:0] KIND_DOUBLE = 2'd3;

  // character codes
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  localparam logic [15:0] FIELD_MAX = 16'hFFFF;

  // one queue word: up to two tokens caused by one text byte; the second
  // one, when present, is always a one-byte symbol
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  kind;
    logic        unterm;
    logic        pair;
    logic [15:0] sym_start;
  } tok_entry_t;

  function automatic logic [15:0] sat_start(input logic [31:0] v);
    return (v > 32'(FIELD_MAX)) ? FIELD_MAX : v[15:0];
  endfunction

  // length held to 1 .. 65535
  function automatic logic [15:0] sat_len(input logic [32:0] v);
    logic [15:0] r;
    if (v > 33'(FIELD_MAX)) r = FIELD_MAX;
    else if (v == '0)       r = 16'd1;
    else                    r = v[15:0];
    return r;
  endfunction

endpackage

/* design/mt_front.sv */
// ----------------------------------------------------------------------------
// mt_front
// Lexer front end: takes one text byte per cycle while the queue is not full,
// tracks lexer mode and byte positions, and queues the tokens each byte closes.
// ----------------------------------------------------------------------------
module mt_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_text,
  input  logic              q_full,
  output logic              push_valid,
  output mt_pkg::tok_entry_t push_data
);
  import mt_pkg::*;

  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_IDENT   = 2'd1;
  localparam logic [1:0] MODE_SINGLE  = 2'd2;
  localparam logic [1:0] MODE_DOUBLE  = 2'd3;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [1:0]               mode_r, mode_nxt, mode_step;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] begin_r, begin_nxt, begin_step;
  logic                     esc_r, esc_nxt, esc_step;

  logic                     accept;
  logic                     is_space, is_symbol;
  logic [7:0]               closer;
  logic [POSITION_BITS-1:0] span, flush_span;
  logic                     a_emit, b_emit, a_unterm;
  logic [31:0]              a_start_w;
  logic [32:0]              a_len_w;
  logic [1:0]               a_kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_space  = (in_text_byte == CH_SPACE) || (in_text_byte == CH_TAB) ||
                     (in_text_byte == CH_NEWLINE) || (in_text_byte == CH_RETURN);
  assign is_symbol = (in_text_byte == CH_LT) || (in_text_byte == CH_GT) ||
                     (in_text_byte == CH_SLASH) || (in_text_byte == CH_EQUAL);
  assign closer    = (mode_r == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

  // begin never passes pos: both reset together and pos only counts up
  assign span       = pos_r - begin_r;
  assign flush_span = pos_r - begin_step;

  always_comb begin
    a_emit     = 1'b0;
    b_emit     = 1'b0;
    a_unterm   = 1'b0;
    a_start_w  = 32'(begin_r);
    a_len_w    = 33'(span);
    a_kind     = KIND_IDENT;
    mode_step  = mode_r;
    begin_step = begin_r;
    esc_step   = esc_r;

    unique case (mode_r)
      MODE_IDENT: begin
        if (is_space || is_symbol) begin
          a_emit    = 1'b1;
          b_emit    = is_symbol;
          mode_step = MODE_BETWEEN;
        end
      end
      MODE_SINGLE, MODE_DOUBLE: begin
        if (esc_r) begin
          esc_step = 1'b0;
        end else if (in_text_byte == closer) begin
          a_emit    = 1'b1;
          a_len_w   = 33'(span) + 33'd1;
          a_kind    = (mode_r == MODE_SINGLE) ? KIND_SINGLE : KIND_DOUBLE;
          mode_step = MODE_BETWEEN;
        end else if (in_text_byte == CH_BACKSLASH) begin
          esc_step = 1'b1;
        end
      end
      default: begin
        if (in_text_byte == CH_SQUOTE) begin
          mode_step  = MODE_SINGLE;
          begin_step = pos_r;
        end else if (in_text_byte == CH_DQUOTE) begin
          mode_step  = MODE_DOUBLE;
          begin_step = pos_r;
        end else if (is_symbol) begin
          a_emit    = 1'b1;
          a_start_w = 32'(pos_r);
          a_len_w   = 33'd1;
          a_kind    = KIND_SYMBOL;
        end else if (!is_space) begin
          mode_step  = MODE_IDENT;
          begin_step = pos_r;
        end
      end
    endcase

    mode_nxt  = mode_step;
    begin_nxt = begin_step;
    esc_nxt   = esc_step;
    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

    // end of text: a flush or the error word always lands in the first slot,
    // which is free in every case that reaches here
    if (in_end_of_text) begin
      if (mode_step == MODE_IDENT) begin
        a_emit    = 1'b1;
        a_start_w = 32'(begin_step);
        a_len_w   = 33'(flush_span) + 33'd1;
        a_kind    = KIND_IDENT;
      end else if (mode_step == MODE_SINGLE || mode_step == MODE_DOUBLE) begin
        a_emit    = 1'b1;
        a_unterm  = 1'b1;
        a_start_w = '0;
        a_len_w   = '0;
        a_kind    = KIND_IDENT;
      end
      mode_nxt  = MODE_BETWEEN;
      begin_nxt = '0;
      esc_nxt   = 1'b0;
      pos_nxt   = '0;
    end
  end

  assign push_valid          = accept && a_emit;
  assign push_data.start     = sat_start(a_start_w);
  assign push_data.length    = a_unterm ? '0 : sat_len(a_len_w);
  assign push_data.kind      = a_kind;
  assign push_data.unterm    = a_unterm;
  assign push_data.pair      = b_emit;
  assign push_data.sym_start = sat_start(32'(pos_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BETWEEN;
      pos_r   <= '0;
      begin_r <= '0;
      esc_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule

/* design/mt_queue.sv */
// ----------------------------------------------------------------------------
// mt_queue
// Short FIFO of token words between the lexer front end and the output stage.
// ----------------------------------------------------------------------------
module mt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  mt_pkg::tok_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output mt_pkg::tok_entry_t head
);
  import mt_pkg::*;

  tok_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

/* design/mt_back.sv */
// ----------------------------------------------------------------------------
// mt_back
// Output stage: unpacks queue words into single tokens and holds each in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module mt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  mt_pkg::tok_entry_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_token_start,
  output logic [15:0]        out_token_length,
  output logic [1:0]         out_token_kind,
  output logic               out_unterminated,
  output logic               out_last_of_run
);
  import mt_pkg::*;

  logic        valid_r;
  logic        second_r;   // first token of a pair already sent
  logic [15:0] start_r, length_r;
  logic [1:0]  kind_r;
  logic        unterm_r, last_r;
  logic        load;

  assign load = (!valid_r || out_ready) && !q_empty;
  assign pop  = load && (second_r || !head.pair);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      valid_r  <= 1'b1;
      second_r <= head.pair && !second_r;
    end else if (out_ready) begin
      valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_r) begin
        start_r  <= head.sym_start;
        length_r <= 16'd1;
        kind_r   <= KIND_SYMBOL;
        unterm_r <= 1'b0;
        last_r   <= 1'b1;
      end else begin
        start_r  <= head.start;
        length_r <= head.length;
        kind_r   <= head.kind;
        unterm_r <= head.unterm;
        last_r   <= !head.pair;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_token_start  = start_r;
  assign out_token_length = length_r;
  assign out_token_kind   = kind_r;
  assign out_unterminated = unterm_r;
  assign out_last_of_run  = last_r;

endmodule

/* design/markup_tokenizer.sv */
// ----------------------------------------------------------------------------
// markup_tokenizer
// Splits a markup byte stream into identifier, symbol and quoted-string tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one text byte per word, with
//   in_end_of_text high on the last byte of a text. Result channel
//   (out_valid/out_ready): one token per word, as start, length and kind;
//   out_last_of_run marks the last token caused by one byte, and
//   out_unterminated flags a text that ended inside a string.
//   Throughput: one byte per cycle while the queue is not full. A byte that
//   closes an identifier with a symbol gives two tokens, sent one after the
//   other by the single output register. Each byte's word enters the queue,
//   then its first token loads into the output register once that is free.
//   A four-word queue sits between the lexer and the output register, so
//   bytes keep flowing while a result waits; in_ready falls only once the
//   queue is full. A stalled result holds steady until taken.
//   Reset clears the lexer to the between-tokens state at position zero and
//   empties the queue; the end-of-text byte does the same for the lexer.
// ----------------------------------------------------------------------------
module markup_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [1:0]  out_token_kind,
  output logic        out_unterminated,
  output logic        out_last_of_run
);
  import mt_pkg::*;

  logic       push_valid, q_full, q_empty, pop;
  tok_entry_t push_data, head;

  mt_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_end_of_text(in_end_of_text),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  mt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  mt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_start (out_token_start),
    .out_token_length(out_token_length),
    .out_token_kind  (out_token_kind),
    .out_unterminated(out_unterminated),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* design/mt_checker.sv */
// ----------------------------------------------------------------------------
// mt_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
module mt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic [1:0]  out_token_kind,
  input logic        out_unterminated,
  input logic        out_last_of_run
);
  import mt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_start) &&
      $stable(out_token_length) && $stable(out_token_kind) &&
      $stable(out_unterminated) && $stable(out_last_of_run))
    else $error("result word changed while stalled");

  // error word carries no token and always ends its run
  a_unterm_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unterminated |-> out_token_start == '0 &&
      out_token_length == '0 && out_token_kind == KIND_IDENT && out_last_of_run)
    else $error("malformed unterminated-string word");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_unterminated |-> out_token_length != '0)
    else $error("token of zero length");

  a_symbol_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_unterminated && out_token_kind == KIND_SYMBOL
      |-> out_token_length == 16'd1)
    else $error("symbol token longer than one byte");

  // only an identifier closed by a symbol shares its byte with another token
  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> out_token_kind == KIND_IDENT &&
      !out_unterminated)
    else $error("unexpected first token of a pair");

endmodule

bind markup_tokenizer mt_checker u_mt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_start (out_token_start),
  .out_token_length(out_token_length),
  .out_token_kind  (out_token_kind),
  .out_unterminated(out_unterminated),
  .out_last_of_run (out_last_of_run)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for markup_tokenizer: drives byte streams through the
// valid/ready input, predicts tokens from its own lexer model or typed-in rows
// and checks each output word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mt_pkg::*;

  localparam int POS_BITS       = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_BYTES   = 1700;
  localparam int HOLD_CYCLES    = 80;
  localparam int FROM_PREDICTOR = -1;

  typedef enum logic [2:0] {LX_BETWEEN, LX_IDENT, LX_SINGLE, LX_DOUBLE} lex_mode_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  kind;
    logic        unterm;
    logic        last;
  } tok_t;

  // n_typed: FROM_PREDICTOR, or the number of tokens typed in below (0 or 1)
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    int         n_typed;
    tok_t       want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [1:0]  out_token_kind;
  logic        out_unterminated;
  logic        out_last_of_run;

  markup_tokenizer #(.POSITION_BITS(POS_BITS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_token_kind   (out_token_kind),
    .out_unterminated (out_unterminated),
    .out_last_of_run  (out_last_of_run)
  );

  // lexer model state
  lex_mode_t           mode_q      = LX_BETWEEN;
  logic [POS_BITS-1:0] pos_q       = '0;
  logic [POS_BITS-1:0] tok_begin_q = '0;
  logic                esc_q       = 1'b0;
  tok_t                step_tok [2];
  int                  step_n      = 0;

  tok_t       tok_expect_q [$];
  logic [7:0] text_q [$];
  dir_row_t   dir_q [$];

  int   cur_typed_n   = FROM_PREDICTOR;
  tok_t cur_typed_tok = '0;
  logic tx_steady     = 1'b0;
  logic rx_steady     = 1'b0;
  int   rx_hold_cycles = 0;

  int bad_cnt     = 0;
  int idle_cycles = 0;
  int n_bytes     = 0;
  int n_texts     = 0;
  int n_tokens    = 0;
  int n_unterm    = 0;

  always #5 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_RETURN;
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == CH_LT || c == CH_GT || c == CH_SLASH || c == CH_EQUAL;
  endfunction

  function automatic tok_t make_tok(input logic [32:0] start, input logic [32:0] len,
                                    input logic [1:0] kind, input logic unterm);
    tok_t t;
    t.start  = (start > 33'(FIELD_MAX)) ? FIELD_MAX : start[15:0];
    if (len > 33'(FIELD_MAX))    t.length = FIELD_MAX;
    else if (len == 0 && !unterm) t.length = 16'd1;
    else                          t.length = len[15:0];
    t.kind   = kind;
    t.unterm = unterm;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic void add_tok(input tok_t t);
    step_tok[step_n] = t;
    step_n++;
  endfunction

  // bytes from the open token's start up to p, p excluded
  function automatic logic [32:0] span_to(input logic [POS_BITS-1:0] p);
    return (p > tok_begin_q) ? 33'(p - tok_begin_q) : 33'd0;
  endfunction

  // advance the lexer model by one byte; tokens land in step_tok[0..step_n-1]
  function automatic void tokenize_byte(input logic [7:0] c, input logic eot);
    logic [POS_BITS-1:0] p;
    logic [7:0]          closer;
    logic [1:0]          str_kind;
    p      = pos_q;
    step_n = 0;
    case (mode_q)
      LX_IDENT: begin
        if (is_blank(c) || is_symbol(c)) begin
          add_tok(make_tok(33'(tok_begin_q), span_to(p), KIND_IDENT, 1'b0));
          if (is_symbol(c)) add_tok(make_tok(33'(p), 33'd1, KIND_SYMBOL, 1'b0));
          mode_q = LX_BETWEEN;
        end
      end
      LX_SINGLE, LX_DOUBLE: begin
        closer   = (mode_q == LX_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        str_kind = (mode_q == LX_SINGLE) ? KIND_SINGLE : KIND_DOUBLE;
        if (esc_q) begin
          esc_q = 1'b0;
        end else if (c == closer) begin
          add_tok(make_tok(33'(tok_begin_q), span_to(p) + 33'd1, str_kind, 1'b0));
          mode_q = LX_BETWEEN;
        end else if (c == CH_BACKSLASH) begin
          esc_q = 1'b1;
        end
      end
      default: begin
        mode_q = LX_BETWEEN;
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          mode_q      = (c == CH_SQUOTE) ? LX_SINGLE : LX_DOUBLE;
          tok_begin_q = p;
        end else if (is_symbol(c)) begin
          add_tok(make_tok(33'(p), 33'd1, KIND_SYMBOL, 1'b0));
        end else if (!is_blank(c)) begin
          mode_q      = LX_IDENT;
          tok_begin_q = p;
        end
      end
    endcase
    if (eot) begin
      if (mode_q == LX_IDENT)
        add_tok(make_tok(33'(tok_begin_q), span_to(p) + 33'd1, KIND_IDENT, 1'b0));
      else if (mode_q == LX_SINGLE || mode_q == LX_DOUBLE)
        add_tok(make_tok(33'd0, 33'd0, KIND_IDENT, 1'b1));
      mode_q      = LX_BETWEEN;
      pos_q       = '0;
      tok_begin_q = '0;
      esc_q       = 1'b0;
    end else if (pos_q != '1) begin
      pos_q = pos_q + 1'b1;
    end
    if (step_n > 0) step_tok[step_n-1].last = 1'b1;
  endfunction

  function automatic void report_bad(input string why, input tok_t want, input tok_t got);
    bad_cnt++;
    if (bad_cnt <= MAX_REPORTS) begin
      $display("tb: mismatch (%s) at %0t", why, $realtime);
      $display("tb:   expected start=%0d len=%0d kind=%0d unterm=%0b last=%0b",
               want.start, want.length, want.kind, want.unterm, want.last);
      $display("tb:   actual   start=%0d len=%0d kind=%0d unterm=%0b last=%0b",
               got.start, got.length, got.kind, got.unterm, got.last);
    end
  endfunction

  function automatic logic [7:0] ident_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (is_blank(b) || is_symbol(b) || b == CH_SQUOTE || b == CH_DQUOTE)
      b = 8'h61 + 8'($urandom_range(0, 25));
    return b;
  endfunction

  // append one well-formed piece of markup; kind_hi above 6 allows raw noise
  function automatic void add_piece(input int kind_hi);
    int         len;
    int         pick;
    logic [7:0] b;
    logic [7:0] closer;
    len  = $urandom_range(1, 6);
    pick = $urandom_range(0, kind_hi);
    case (pick)
      0, 1, 2: begin
        text_q.push_back(ident_byte());
        for (int k = 1; k < len; k++) begin
          // quotes inside an identifier are plain identifier bytes
          if ($urandom_range(0, 5) == 0)
            text_q.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
          else
            text_q.push_back(ident_byte());
        end
      end
      3: begin
        case ($urandom_range(0, 3))
          0:       b = CH_LT;
          1:       b = CH_GT;
          2:       b = CH_SLASH;
          default: b = CH_EQUAL;
        endcase
        text_q.push_back(b);
      end
      4: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0:       b = CH_SPACE;
            1:       b = CH_TAB;
            2:       b = CH_NEWLINE;
            default: b = CH_RETURN;
          endcase
          text_q.push_back(b);
        end
      end
      5, 6: begin
        closer = (pick == 5) ? CH_SQUOTE : CH_DQUOTE;
        // leading blank keeps the opening quote out of a preceding identifier
        text_q.push_back(CH_SPACE);
        text_q.push_back(closer);
        for (int k = 1; k < len; k++) begin
          b = 8'($urandom);
          if (b == closer || b == CH_BACKSLASH || $urandom_range(0, 7) == 0)
            text_q.push_back(CH_BACKSLASH);
          text_q.push_back(b);
        end
        text_q.push_back(closer);
      end
      default: text_q.push_back(8'($urandom));
    endcase
  endfunction

  function automatic void gen_text();
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) add_piece(7);
      // sometimes the text ends inside a string
      if ($urandom_range(0, 7) == 0) begin
        text_q.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
        repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom));
      end
    end
  endfunction

  function automatic void dir_exp(input logic [7:0] ch, input logic eot, input int n,
                                  input logic [15:0] start, input logic [15:0] len,
                                  input logic [1:0] kind, input logic unterm);
    dir_row_t r;
    r.ch      = ch;
    r.eot     = eot;
    r.n_typed = n;
    r.want    = {start, len, kind, unterm, 1'b1};
    dir_q.push_back(r);
  endfunction

  function automatic void dir_row(input logic [7:0] ch, input logic eot);
    dir_exp(ch, eot, FROM_PREDICTOR, 16'd0, 16'd0, KIND_IDENT, 1'b0);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] ch, input logic eot);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= ch;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tok_expect_q.size() != 0) @(negedge clk);
  endtask

  // input side: predict on every accepted byte
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tokenize_byte(in_text_byte, in_end_of_text);
      n_bytes++;
      if (in_end_of_text) n_texts++;
      if (cur_typed_n != FROM_PREDICTOR) begin
        if (cur_typed_n == 1) tok_expect_q.push_back(cur_typed_tok);
      end else begin
        for (int k = 0; k < step_n; k++) tok_expect_q.push_back(step_tok[k]);
      end
    end
  end

  // output side: compare against the oldest prediction
  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_token_start, out_token_length, out_token_kind, out_unterminated,
             out_last_of_run};
      n_tokens++;
      if (got.unterm) n_unterm++;
      if (tok_expect_q.size() == 0) begin
        report_bad("word with nothing expected", '0, got);
      end else begin
        want = tok_expect_q.pop_front();
        if (got.start != want.start || got.length != want.length ||
            got.kind != want.kind || got.unterm != want.unterm ||
            got.last != want.last)
          report_bad("field differs", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired, %0d words still expected", tok_expect_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side: random stalls, steady stretches, one long hold-off on request
  initial begin
    int gap;
    int words;
    words = 0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      if (words % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = rx_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      words++;
      @(negedge clk);
    end
  end

  initial begin
    int    rand_bytes;
    string tail;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = 8'h00;
    in_end_of_text = 1'b0;
    out_ready      = 1'b0;
    rand_bytes     = 0;
    tail           = "abcdefghijk=xy 'q'/mn";

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // symbol right after reset, then every token kind and the corner cases
    dir_exp(CH_LT, 1'b0, 1, 16'd0, 16'd1, KIND_SYMBOL, 1'b0);
    dir_row(8'h61, 1'b0);
    dir_row(8'hFF, 1'b0);
    dir_row(CH_DQUOTE, 1'b0);      // quote inside identifier
    dir_row(CH_EQUAL, 1'b0);       // symbol closes identifier: two tokens
    dir_row(CH_SQUOTE, 1'b0);
    dir_row(CH_BACKSLASH, 1'b0);
    dir_row(CH_SQUOTE, 1'b0);      // escaped, string stays open
    dir_row(CH_SQUOTE, 1'b0);
    dir_row(CH_TAB, 1'b0);
    dir_row(CH_DQUOTE, 1'b0);
    dir_row(CH_BACKSLASH, 1'b0);
    dir_row(CH_BACKSLASH, 1'b0);   // escaped backslash starts no new escape
    dir_row(CH_DQUOTE, 1'b0);
    dir_row(CH_SLASH, 1'b0);
    dir_row(CH_NEWLINE, 1'b0);
    dir_row(8'h00, 1'b0);
    dir_row(CH_GT, 1'b0);
    dir_row(CH_RETURN, 1'b0);
    dir_row(8'h7A, 1'b1);          // identifier flushed on the last byte
    dir_exp(CH_SQUOTE, 1'b1, 1, 16'd0, 16'd0, KIND_IDENT, 1'b1);
    dir_exp(8'h78, 1'b1, 1, 16'd0, 16'd1, KIND_IDENT, 1'b0);
    dir_row(CH_DQUOTE, 1'b0);
    dir_exp(CH_BACKSLASH, 1'b1, 1, 16'd0, 16'd0, KIND_IDENT, 1'b1);
    dir_exp(CH_SPACE, 1'b1, 0, 16'd0, 16'd0, KIND_IDENT, 1'b0);
    dir_exp(CH_GT, 1'b1, 1, 16'd0, 16'd1, KIND_SYMBOL, 1'b0);

    for (int r = 0; r < dir_q.size(); r++) begin
      cur_typed_n   = dir_q[r].n_typed;
      cur_typed_tok = dir_q[r].want;
      send_byte(dir_q[r].ch, dir_q[r].eot);
    end
    cur_typed_n = FROM_PREDICTOR;
    wait_drained();

    // back-pressure: receiver holds off while a flood of symbols comes in
    tx_steady      = 1'b1;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (24) send_byte(CH_SLASH, 1'b0);
    send_byte(CH_GT, 1'b1);
    wait_drained();

    while (rand_bytes < RANDOM_BYTES) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      gen_text();
      for (int i = 0; i < text_q.size(); i++)
        send_byte(text_q[i], i == text_q.size() - 1);
      rand_bytes += text_q.size();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    // closing text mixes identifiers, symbols and a single-quoted string and ends on an open identifier
    tx_steady = 1'b0;
    for (int i = 0; i < tail.len(); i++) send_byte(tail[i], i == tail.len() - 1);
    wait_drained();

    repeat (4) @(negedge clk);
    $display("tb: %0d bytes in %0d texts, incl. a long receiver hold-off", n_bytes,
             n_texts);
    $display("tb: %0d tokens checked, %0d of them unterminated-string words",
             n_tokens, n_unterm);
    if (bad_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/mt_pkg.sv
design/mt_front.sv
design/mt_queue.sv
design/mt_back.sv
design/markup_tokenizer.sv
design/mt_checker.sv
tb/sv/tb.sv
